// ===== design/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
`timescale 1ns / 1ps

package stq_pkg;

    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 4;
    localparam int DELAY_W  = 16;
    localparam int KIND_W   = 2;

    // A tick reports at most this many expiries; the rest wait for the next tick.
    localparam int MAX_POPS = 16;
    localparam int POPIDX_W = $clog2(MAX_POPS);
    localparam int POPCNT_W = $clog2(MAX_POPS + 1);

    localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    typedef struct packed {
        logic                accept;
        logic                tick;
        logic                remove;
        logic                insert;
        logic                pop;
        logic                load;
        logic                fired;
        logic                last;
        logic [POPIDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic room;
        logic due;
        logic out_free;
    } t_status;

endpackage

// ===== design/stq_ctrl.sv =====
// Sequencer for the sorted timer queue: steps each command through the datapath.
`timescale 1ns / 1ps

module stq_ctrl
    import stq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_ready,
    input  t_status           i_status,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_POP,
        ST_RESP,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [KIND_W-1:0]   r_kind;
    logic [POPCNT_W-1:0] r_npop;
    logic [POPIDX_W-1:0] r_eidx;
    logic                accept;
    logic                pop_now;
    logic                emit_last;

    assign o_ready   = (r_state == ST_IDLE);
    assign accept    = o_ready && i_valid;
    assign pop_now   = (r_npop < POPCNT_W'(MAX_POPS)) && i_status.due;
    assign emit_last = ({1'b0, r_eidx} == (r_npop - POPCNT_W'(1)));

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = accept;
        o_cmd.tick   = accept && (i_kind == KIND_TICK);
        o_cmd.idx    = r_eidx;
        case (r_state)
            ST_REMOVE: o_cmd.remove = 1'b1;
            ST_INSERT: o_cmd.insert = 1'b1;
            ST_POP: begin
                o_cmd.pop = pop_now;
                o_cmd.idx = r_npop[POPIDX_W-1:0];
            end
            ST_RESP: begin
                o_cmd.load = i_status.out_free;
                o_cmd.last = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.load  = i_status.out_free;
                o_cmd.fired = 1'b1;
                o_cmd.last  = emit_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= KIND_ARM;
            r_npop  <= '0;
            r_eidx  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_kind <= i_kind;
                        r_npop <= '0;
                        r_eidx <= '0;
                        if (i_kind == KIND_ARM || i_kind == KIND_CANCEL) begin
                            r_state <= ST_REMOVE;
                        end else if (i_kind == KIND_TICK) begin
                            r_state <= ST_POP;
                        end else begin
                            r_state <= ST_RESP;
                        end
                    end
                end
                ST_REMOVE: begin
                    r_state <= (r_kind == KIND_ARM) ? ST_INSERT : ST_RESP;
                end
                ST_INSERT: begin
                    r_state <= ST_RESP;
                end
                ST_POP: begin
                    if (pop_now) begin
                        r_npop <= r_npop + POPCNT_W'(1);
                    end else if (r_npop == '0) begin
                        r_state <= ST_RESP;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_RESP: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (i_status.out_free) begin
                        r_eidx <= r_eidx + POPIDX_W'(1);
                        if (emit_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // A pop is only ever issued while the head is due and the tick budget is not spent.
    a_pop_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> i_status.due && (r_npop < POPCNT_W'(MAX_POPS)))
        else $error("pop issued without a due head");

    // Every tick that enters the pop phase finishes with at most the budgeted pops.
    a_npop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_npop <= POPCNT_W'(MAX_POPS))
        else $error("pop count beyond budget");

    // Reported expiries are never more than the pops that produced them.
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ({1'b0, r_eidx} < r_npop))
        else $error("emit index beyond popped entries");

endmodule

// ===== design/stq_datapath.sv =====
// Sorted entry row, time counter, pop buffer and result register of the timer queue.
`timescale 1ns / 1ps

module stq_datapath
    import stq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [DELAY_W-1:0]  i_delay,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_ready,
    output logic                o_valid,
    output logic                o_fired,
    output logic [HANDLE_W-1:0] o_expired_handle,
    output logic [TIME_W-1:0]   o_next_deadline,
    output logic                o_queue_empty,
    output logic                o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    // Entry row, kept in expiry order; only the first r_count cells are meaningful.
    logic [HANDLE_W-1:0] r_h [DEPTH];
    logic [TIME_W-1:0]   r_e [DEPTH];
    logic [HANDLE_W-1:0] n_h [DEPTH];
    logic [TIME_W-1:0]   n_e [DEPTH];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_exp;
    logic [HANDLE_W-1:0] r_hnd;
    logic [IW-1:0]       r_pos;
    logic                r_found;
    logic [HANDLE_W-1:0] r_buf [MAX_POPS];

    logic                r_out_valid;
    logic                r_fired;
    logic [HANDLE_W-1:0] r_out_h;
    logic [TIME_W-1:0]   r_deadline;
    logic                r_empty;
    logic                r_last;

    logic [DEPTH-1:0]    match;
    logic [DEPTH-1:0]    le;
    logic [IW-1:0]       match_pos;
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   arm_exp;
    logic                q_empty;

    assign q_empty = (r_count == '0);
    assign sum     = {1'b0, r_now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, i_delay};
    assign arm_exp = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    // Handles are unique in the row, so at most one cell matches.
    always_comb begin
        match_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (CW'(i) < r_count) && (r_h[i] == i_handle);
            if (match[i]) begin
                match_pos = match_pos | IW'(i);
            end
        end
    end

    // The row is sorted, so le is a run of ones followed by zeros.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            le[i] = (CW'(i) < r_count) && (r_e[i] <= r_exp);
        end
    end

    always_comb begin
        n_h     = r_h;
        n_e     = r_e;
        n_count = r_count;
        if (i_cmd.remove && r_found) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (IW'(i) >= r_pos) begin
                    n_h[i] = r_h[i+1];
                    n_e[i] = r_e[i+1];
                end
            end
            n_count = r_count - CW'(1);
        end
        if (i_cmd.insert && o_status.room) begin
            // The new entry lands after every entry with an equal or earlier expiry.
            if (!le[0]) begin
                n_h[0] = r_hnd;
                n_e[0] = r_exp;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (!le[i]) begin
                    if (le[i-1]) begin
                        n_h[i] = r_hnd;
                        n_e[i] = r_exp;
                    end else begin
                        n_h[i] = r_h[i-1];
                        n_e[i] = r_e[i-1];
                    end
                end
            end
            n_count = r_count + CW'(1);
        end
        if (i_cmd.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_h[i] = r_h[i+1];
                n_e[i] = r_e[i+1];
            end
            n_count = r_count - CW'(1);
        end
    end

    assign o_status = '{
        found:    r_found,
        room:     (r_count < CW'(DEPTH)),
        due:      !q_empty && (r_e[0] <= r_now),
        out_free: !r_out_valid || i_ready
    };

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        r_e <= n_e;
        if (i_cmd.accept) begin
            r_exp   <= arm_exp;
            r_hnd   <= i_handle;
            r_pos   <= match_pos;
            r_found <= |match;
        end
        if (i_cmd.pop) begin
            r_buf[i_cmd.idx] <= r_h[0];
        end
        if (i_cmd.load) begin
            r_fired    <= i_cmd.fired;
            r_out_h    <= i_cmd.fired ? r_buf[i_cmd.idx] : '0;
            r_deadline <= q_empty ? '0 : r_e[0];
            r_empty    <= q_empty;
            r_last     <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_now       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.tick) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_fired          = r_fired;
    assign o_expired_handle = r_out_h;
    assign o_next_deadline  = r_deadline;
    assign o_queue_empty    = r_empty;
    assign o_last           = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (r_e[0] <= r_e[1]))
        else $error("queue head out of expiry order");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not shrink the queue");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.insert && o_status.room) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the queue");

endmodule

// ===== design/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: sequencer plus datapath.
`timescale 1ns / 1ps

// Keeps up to DEPTH timers in expiry order with a seconds counter. Items are taken one
// at a time; the next item is accepted once every result of the previous one has been
// loaded into the output register, so a waiting result does not block the next transfer.
// An arm steps through accept with handle search, removal shift, insertion shift and
// result; a cancel skips the insertion shift and an unused kind goes straight to its
// result. A tick pops each of n expiries (n at most 16) by one shift of the entry row into
// a pop buffer, then reports one result per expiry, or a single result if none is due.
// Output stalls hold the result steps. The results of a tick all carry the head deadline
// and empty flag of the queue after the whole tick.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [DELAY_W-1:0]  i_delay,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_fired,
    output logic [HANDLE_W-1:0] o_expired_handle,
    output logic [TIME_W-1:0]   o_next_deadline,
    output logic                o_queue_empty,
    output logic                o_last
);

    t_cmd    cmd;
    t_status status;

    stq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    stq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_handle         (i_handle),
        .i_delay          (i_delay),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_fired          (o_fired),
        .o_expired_handle (o_expired_handle),
        .o_next_deadline  (o_next_deadline),
        .o_queue_empty    (o_queue_empty),
        .o_last           (o_last)
    );

endmodule

// ===== sim/tb_sorted_timer_queue.sv =====
// Self-checking testbench for the sorted timer queue: directed and random commands.
`timescale 1ns / 1ps

module tb_sorted_timer_queue
    import stq_pkg::*;
();

    localparam int QUEUE_DEPTH  = 16;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 84;
    localparam int REPORT_LIMIT = 10;

    // Kind value that the block treats as a no-op status request.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic                fired;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   deadline;
        logic                empty;
        logic                last;
    } t_timer_report;

    class timer_scoreboard;
        logic [HANDLE_W-1:0] slot_owner[QUEUE_DEPTH];
        logic [TIME_W-1:0]   slot_due[QUEUE_DEPTH];
        int unsigned         queued;
        logic [TIME_W-1:0]   now_s;
        t_timer_report       due_reports[$];
        int                  mismatches;

        function new();
            queued     = 0;
            now_s      = '0;
            mismatches = 0;
        endfunction

        function void remove_slot(int unsigned pos);
            for (int unsigned i = pos; i + 1 < queued; i++) begin
                slot_owner[i] = slot_owner[i + 1];
                slot_due[i]   = slot_due[i + 1];
            end
            queued--;
        endfunction

        function void drop_handle(logic [HANDLE_W-1:0] handle);
            for (int unsigned i = 0; i < queued; i++) begin
                if (slot_owner[i] == handle) begin
                    remove_slot(i);
                    return;
                end
            end
        endfunction

        // Works out the reports one accepted command produces and queues them.
        function void note_command(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                                   logic [DELAY_W-1:0] delay);
            logic [TIME_W:0]     sum;
            logic [TIME_W-1:0]   expiry;
            logic [HANDLE_W-1:0] popped[$];
            t_timer_report       rep;
            int unsigned         pos;
            case (kind)
                KIND_ARM: begin
                    sum    = {1'b0, now_s} + delay;
                    expiry = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    drop_handle(handle);
                    if (queued < QUEUE_DEPTH) begin
                        // Equal expiries keep arrival order, so search past them.
                        pos = 0;
                        while (pos < queued && slot_due[pos] <= expiry) pos++;
                        for (int unsigned i = queued; i > pos; i--) begin
                            slot_owner[i] = slot_owner[i - 1];
                            slot_due[i]   = slot_due[i - 1];
                        end
                        slot_owner[pos] = handle;
                        slot_due[pos]   = expiry;
                        queued++;
                    end
                end
                KIND_CANCEL: drop_handle(handle);
                KIND_TICK: begin
                    now_s = now_s + 1;
                    while (popped.size() < MAX_POPS && queued > 0 &&
                           slot_due[0] <= now_s) begin
                        popped.push_back(slot_owner[0]);
                        remove_slot(0);
                    end
                end
                default: ;
            endcase
            rep.deadline = (queued > 0) ? slot_due[0] : '0;
            rep.empty    = (queued == 0);
            if (popped.size() == 0) begin
                rep.fired  = 1'b0;
                rep.handle = '0;
                rep.last   = 1'b1;
                due_reports.push_back(rep);
            end else begin
                foreach (popped[k]) begin
                    rep.fired  = 1'b1;
                    rep.handle = popped[k];
                    rep.last   = (k == popped.size() - 1);
                    due_reports.push_back(rep);
                end
            end
        endfunction

        function void check_report(t_timer_report got);
            t_timer_report want;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result fired=%0b handle=%0d deadline=%0d %s%0b %s%0b",
                             $realtime, got.fired, got.handle, got.deadline,
                             "empty=", got.empty, "last=", got.last);
                return;
            end
            want = due_reports.pop_front();
            if (got.fired !== want.fired || got.handle !== want.handle ||
                got.deadline !== want.deadline || got.empty !== want.empty ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected fired=%0b handle=%0d deadline=%0d empty=%0b last=%0b",
                             want.fired, want.handle, want.deadline, want.empty, want.last);
                    $display("  actual   fired=%0b handle=%0d deadline=%0d empty=%0b last=%0b",
                             got.fired, got.handle, got.deadline, got.empty, got.last);
                end
            end
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function bit clean();
            return mismatches == 0 && due_reports.size() == 0;
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [KIND_W-1:0]   i_kind;
    logic [HANDLE_W-1:0] i_handle;
    logic [DELAY_W-1:0]  i_delay;
    logic                o_valid;
    logic                i_ready;
    logic                o_fired;
    logic [HANDLE_W-1:0] o_expired_handle;
    logic [TIME_W-1:0]   o_next_deadline;
    logic                o_queue_empty;
    logic                o_last;

    timer_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    bit              hold_request;
    int unsigned     cycle_count;

    sorted_timer_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_handle         (i_handle),
        .i_delay          (i_delay),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_fired          (o_fired),
        .o_expired_handle (o_expired_handle),
        .o_next_deadline  (o_next_deadline),
        .o_queue_empty    (o_queue_empty),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: sample at the rising edge, change ready at the falling edge.
    initial begin
        int            hold_left;
        t_timer_report seen;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_ready) begin
                seen.fired    = o_fired;
                seen.handle   = o_expired_handle;
                seen.deadline = o_next_deadline;
                seen.empty    = o_queue_empty;
                seen.last     = o_last;
                sb.check_report(seen);
            end
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one command and returns at the rising edge where its transfer happens.
    task automatic send_command(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] handle,
                                input logic [DELAY_W-1:0] delay);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind   = kind;
        i_handle = handle;
        i_delay  = delay;
        i_valid  = 1'b1;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_command(kind, handle, delay);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Short delays keep the queue busy with expiries; long ones park entries far ahead.
    task automatic send_random();
        int                  pick;
        logic [KIND_W-1:0]   kind;
        logic [DELAY_W-1:0]  delay;
        pick  = $urandom_range(99);
        delay = DELAY_W'($urandom_range(65535));
        if (pick < 40) begin
            kind  = KIND_ARM;
            delay = DELAY_W'($urandom_range(6));
        end else if (pick < 47) begin
            kind = KIND_ARM;
        end else if (pick < 60) begin
            kind = KIND_CANCEL;
        end else if (pick < 97) begin
            kind = KIND_TICK;
        end else begin
            kind = KIND_NONE;
        end
        send_command(kind, HANDLE_W'($urandom_range(15)), delay);
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = KIND_ARM;
        i_handle      = '0;
        i_delay       = '0;
        i_ready       = 1'b0;
        hold_request  = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 59;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty queue: tick with nothing due, unused kind, cancel of an absent handle.
        send_command(KIND_TICK, 4'd0, 16'd0);
        send_command(KIND_NONE, 4'd9, 16'hA5A5);
        send_command(KIND_CANCEL, 4'd5, 16'd0);
        send_command(KIND_ARM, 4'd15, 16'hFFFF);
        send_command(KIND_ARM, 4'd0, 16'd0);
        send_command(KIND_ARM, 4'd15, 16'd3);
        send_command(KIND_CANCEL, 4'd15, 16'd0);
        send_command(KIND_TICK, 4'd15, 16'hFFFF);
        // Fill every slot with two groups of equal expiry, rearm one while full,
        // then a single tick reports the maximum number of expiries.
        for (int h = 0; h < QUEUE_DEPTH; h++)
            send_command(KIND_ARM, h[HANDLE_W-1:0], {15'd0, h[0]});
        send_command(KIND_ARM, 4'd4, 16'd0);
        send_command(KIND_TICK, 4'd0, 16'd0);
        send_command(KIND_TICK, 4'd0, 16'd0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 21 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 0 && i == 40) hold_request = 1'b1;
                send_random();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.clean())
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/stq_pkg.sv
design/stq_ctrl.sv
design/stq_datapath.sv
design/sorted_timer_queue.sv
sim/tb_sorted_timer_queue.sv
